### rtl/core/sequenced_record_validator_unit_macros.svh
// ----------------------------------------------------------------------------
// sequenced record validator assertion macros
// concurrent check helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_RECORD_VALIDATOR_UNIT_MACROS_SVH
`define SEQUENCED_RECORD_VALIDATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// property holds at every edge out of reset
`define SRVU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent at one edge implies consequent at the next
`define SRVU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SRVU_ASSERT(label, clk, rst_n, prop, msg)
`define SRVU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/srv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srv_pkg
// shared types, status codes, register indexes and check limits
// ----------------------------------------------------------------------------
package srv_pkg;

	localparam int SEQ_W       = 16;
	localparam int STATUS_W    = 4;
	localparam int COUNT_W     = 32;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_PUBLISHED   = 4'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 4'd1;
	localparam logic [STATUS_W-1:0] ST_STALE       = 4'd2;
	localparam logic [STATUS_W-1:0] ST_LENGTH      = 4'd3;
	localparam logic [STATUS_W-1:0] ST_CONDITION   = 4'd4;
	localparam logic [STATUS_W-1:0] ST_TEMPERATURE = 4'd5;
	localparam logic [STATUS_W-1:0] ST_TIME        = 4'd6;
	localparam logic [STATUS_W-1:0] ST_LIFETIME    = 4'd7;
	localparam logic [STATUS_W-1:0] ST_FLAGS       = 4'd8;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_CONDITION = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TTL_MIN       = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TTL_MAX       = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FLAG_MASK     = 8'd3;

	// register reset values
	localparam logic [7:0]  MAX_CONDITION_RST = 8'd4;
	localparam logic [15:0] TTL_MIN_RST       = 16'd1;
	localparam logic [15:0] TTL_MAX_RST       = 16'd1440;
	localparam logic [7:0]  FLAG_MASK_RST     = 8'd3;

	// fixed field limits
	localparam logic [7:0]         LEN_REQUIRED = 8'd10;
	localparam logic signed [15:0] TEMP_MIN     = -16'sd500;
	localparam logic signed [15:0] TEMP_MAX     = 16'sd600;
	localparam logic [31:0]        TIME_MIN     = 32'd1577836800;
	localparam logic [31:0]        TIME_MAX     = 32'd2145916800;
	localparam logic [SEQ_W-1:0]   SEQ_HALF     = 16'h8000;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// classified item between front and back
	typedef struct packed {
		logic [SEQ_W-1:0]    seq;
		logic [STATUS_W-1:0] status;
	} srv_item_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} srv_qstat_t;

endpackage
`default_nettype wire

### rtl/core/srv_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srv channel interfaces
// record input, result output and register write channels
// ----------------------------------------------------------------------------
interface srv_rec_if;
	logic               valid;
	logic               ready;
	logic [15:0]        sequence_req;
	logic [7:0]         length;
	logic [7:0]         condition;
	logic signed [15:0] temperature;
	logic [31:0]        observed_time;
	logic [15:0]        lifetime;
	logic [7:0]         flags;
	logic [31:0]        arrival_ticks;

	modport source (
		output valid, sequence_req, length, condition, temperature,
		       observed_time, lifetime, flags, arrival_ticks,
		input  ready
	);
	modport sink (
		input  valid, sequence_req, length, condition, temperature,
		       observed_time, lifetime, flags, arrival_ticks,
		output ready
	);
endinterface

interface srv_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [31:0] generation;
	logic [15:0] current_sequence;
	logic        has_record;
	logic [31:0] published_count;
	logic [31:0] duplicate_count;
	logic [31:0] stale_count;
	logic [31:0] rejected_count;

	modport source (
		output valid, status, generation, current_sequence, has_record,
		       published_count, duplicate_count, stale_count, rejected_count,
		input  ready
	);
	modport sink (
		input  valid, status, generation, current_sequence, has_record,
		       published_count, duplicate_count, stale_count, rejected_count,
		output ready
	);
endinterface

interface srv_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/srv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srv_front
// holds the check registers, takes records and classifies their fields
// ----------------------------------------------------------------------------
module srv_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	srv_rec_if.sink                 rec,
	srv_cfg_if.sink                 cfg,
	input  wire srv_pkg::srv_qstat_t qstat,
	output logic                    push,
	output srv_pkg::srv_item_t      push_item
);

	logic [7:0]  max_condition_q;
	logic [15:0] ttl_min_q;
	logic [15:0] ttl_max_q;
	logic [7:0]  flag_mask_q;
	logic [srv_pkg::STATUS_W-1:0] code;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_condition_q <= srv_pkg::MAX_CONDITION_RST;
			ttl_min_q       <= srv_pkg::TTL_MIN_RST;
			ttl_max_q       <= srv_pkg::TTL_MAX_RST;
			flag_mask_q     <= srv_pkg::FLAG_MASK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				srv_pkg::CFG_MAX_CONDITION: max_condition_q <= cfg.data[7:0];
				srv_pkg::CFG_TTL_MIN:       ttl_min_q       <= cfg.data;
				srv_pkg::CFG_TTL_MAX:       ttl_max_q       <= cfg.data;
				srv_pkg::CFG_FLAG_MASK:     flag_mask_q     <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// first failing check decides the code
	always_comb begin
		if (rec.length != srv_pkg::LEN_REQUIRED) begin
			code = srv_pkg::ST_LENGTH;
		end else if (rec.condition > max_condition_q) begin
			code = srv_pkg::ST_CONDITION;
		end else if (rec.temperature < srv_pkg::TEMP_MIN ||
		             rec.temperature > srv_pkg::TEMP_MAX) begin
			code = srv_pkg::ST_TEMPERATURE;
		end else if (rec.observed_time < srv_pkg::TIME_MIN ||
		             rec.observed_time > srv_pkg::TIME_MAX) begin
			code = srv_pkg::ST_TIME;
		end else if (rec.lifetime < ttl_min_q || rec.lifetime > ttl_max_q) begin
			code = srv_pkg::ST_LIFETIME;
		end else if ((rec.flags & ~flag_mask_q) != 8'd0 || rec.flags == flag_mask_q) begin
			code = srv_pkg::ST_FLAGS;
		end else begin
			code = srv_pkg::ST_PUBLISHED;
		end
	end

	// arrival_ticks does not take part in any check
	assign rec.ready        = !qstat.full;
	assign push             = rec.valid && !qstat.full;
	assign push_item.seq    = rec.sequence_req;
	assign push_item.status = code;

endmodule
`default_nettype wire

### rtl/core/srv_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srv_queue
// short first-in first-out queue of classified items
// ----------------------------------------------------------------------------
module srv_queue #(
	parameter int DEPTH = srv_pkg::QUEUE_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire srv_pkg::srv_item_t         push_item,
	input  wire logic                       pop,
	output srv_pkg::srv_item_t              pop_item,
	output srv_pkg::srv_qstat_t             qstat,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	srv_pkg::srv_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_item    = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign count       = count_q;

endmodule
`default_nettype wire

### rtl/core/srv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srv_back
// sequence ordering, publication state, event counters and result register
// ----------------------------------------------------------------------------
module srv_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire srv_pkg::srv_qstat_t qstat,
	input  wire srv_pkg::srv_item_t  item,
	output logic                     pop,
	srv_res_if.source                res
);

	logic                          out_valid_q;
	logic [srv_pkg::STATUS_W-1:0]  status_q;
	logic                          has_record_q;
	logic [srv_pkg::SEQ_W-1:0]     last_seq_q;
	logic [srv_pkg::COUNT_W-1:0]   generation_q;
	logic [srv_pkg::COUNT_W-1:0]   published_q;
	logic [srv_pkg::COUNT_W-1:0]   duplicate_q;
	logic [srv_pkg::COUNT_W-1:0]   stale_q;
	logic [srv_pkg::COUNT_W-1:0]   rejected_q;

	logic [srv_pkg::SEQ_W-1:0]     seq_gap;
	logic [srv_pkg::STATUS_W-1:0]  status_next;

	// serial distance from the last published sequence
	assign seq_gap = item.seq - last_seq_q;

	always_comb begin
		if (item.status != srv_pkg::ST_PUBLISHED) begin
			status_next = item.status;
		end else if (has_record_q && item.seq == last_seq_q) begin
			status_next = srv_pkg::ST_DUPLICATE;
		end else if (has_record_q && seq_gap >= srv_pkg::SEQ_HALF) begin
			status_next = srv_pkg::ST_STALE;
		end else begin
			status_next = srv_pkg::ST_PUBLISHED;
		end
	end

	// state only moves when the shown result leaves, so it matches the result
	assign pop = !qstat.empty && (!out_valid_q || res.ready);

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= status_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			has_record_q <= 1'b0;
			last_seq_q   <= '0;
			generation_q <= '0;
			published_q  <= '0;
			duplicate_q  <= '0;
			stale_q      <= '0;
			rejected_q   <= '0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
			if (status_next == srv_pkg::ST_PUBLISHED) begin
				has_record_q <= 1'b1;
				last_seq_q   <= item.seq;
				generation_q <= generation_q + 1'b1;
				if (published_q != srv_pkg::COUNT_MAX) begin
					published_q <= published_q + 1'b1;
				end
			end else if (status_next == srv_pkg::ST_DUPLICATE) begin
				if (duplicate_q != srv_pkg::COUNT_MAX) begin
					duplicate_q <= duplicate_q + 1'b1;
				end
			end else if (status_next == srv_pkg::ST_STALE) begin
				if (stale_q != srv_pkg::COUNT_MAX) begin
					stale_q <= stale_q + 1'b1;
				end
			end else begin
				if (rejected_q != srv_pkg::COUNT_MAX) begin
					rejected_q <= rejected_q + 1'b1;
				end
			end
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.status           = status_q;
	assign res.generation       = generation_q;
	assign res.current_sequence = last_seq_q;
	assign res.has_record       = has_record_q;
	assign res.published_count  = published_q;
	assign res.duplicate_count  = duplicate_q;
	assign res.stale_count      = stale_q;
	assign res.rejected_count   = rejected_q;

endmodule
`default_nettype wire

### rtl/core/sequenced_record_validator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequenced_record_validator_unit
// Checks fixed-format records and publishes the good ones by sequence number.
//
// rec: one record per item (valid/ready). cfg: register writes, always ready,
//   index 0 max_condition, 1 ttl_min_minutes, 2 ttl_max_minutes, 3 flag_mask;
//   other indexes are ignored. Write only while no item is in flight.
// res: one result per record, in order, with the status and the counters
//   after that record.
// Throughput is one item per cycle while res is ready: the front classifies a record in the cycle
// it is taken, and the back resolves duplicate/stale and updates the counters
// as it pops each item. A taken item is written into the queue, then popped into the back's result register.
// A queue of QUEUE_DEPTH items sits between the two halves; when res stalls
// the back holds its result and the queue fills, then rec.ready drops.
// Reset clears the publication state, all counters and the queue, and loads
// the register defaults. arrival_ticks is carried but unused.
// ----------------------------------------------------------------------------
`include "sequenced_record_validator_unit_macros.svh"

module sequenced_record_validator_unit #(
	parameter int QUEUE_DEPTH = srv_pkg::QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	srv_rec_if.sink   rec,
	srv_res_if.source res,
	srv_cfg_if.sink   cfg
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                 push;
	logic                 pop;
	srv_pkg::srv_item_t   push_item;
	srv_pkg::srv_item_t   pop_item;
	srv_pkg::srv_qstat_t  qstat;
	logic [CNT_W-1:0]     q_count;

	srv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (rec),
		.cfg       (cfg),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	srv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat),
		.count     (q_count)
	);

	srv_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.item   (pop_item),
		.pop    (pop),
		.res    (res)
	);

	`SRVU_ASSERT_NEXT(a_queue_fill, clk, arst_n, push && !pop, q_count == $past(q_count) + 1'b1, "queue count did not follow a lone push")
	`SRVU_ASSERT(a_no_record_clean, clk, arst_n, !res.has_record |-> (res.generation == '0 && res.published_count == '0), "state moved without a publication")
	`SRVU_ASSERT(a_publish_sets, clk, arst_n, (res.valid && res.status == srv_pkg::ST_PUBLISHED) |-> res.has_record, "published result without a record")
	`SRVU_ASSERT(a_dup_counted, clk, arst_n, (res.valid && res.status == srv_pkg::ST_DUPLICATE) |-> (res.duplicate_count != '0), "duplicate result not counted")

endmodule
`default_nettype wire

### test/tb_sequenced_record_validator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequenced_record_validator_unit
// Feeds records through the validator under several register settings, with
// bursty input and a stalling result side, and checks every result field
// against a scoreboard that tracks the publication state and counters.
// ----------------------------------------------------------------------------
module tb_sequenced_record_validator_unit;
	import srv_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	localparam logic [7:0]  LIM_LENGTH  = 8'd10;
	localparam int          LIM_TEMP_LO = -500;
	localparam int          LIM_TEMP_HI = 600;
	localparam logic [31:0] LIM_TIME_LO = 32'd1577836800;
	localparam logic [31:0] LIM_TIME_HI = 32'd2145916800;
	localparam logic [15:0] LIM_HALF    = 16'h8000;

	// indexes with no register behind them
	localparam logic [7:0] CFG_UNUSED_LOW = 8'd4;
	localparam logic [7:0] CFG_UNUSED_TOP = 8'hFF;

	typedef struct {
		logic [15:0]        seq;
		logic [7:0]         length;
		logic [7:0]         condition;
		logic signed [15:0] temperature;
		logic [31:0]        observed_time;
		logic [15:0]        lifetime;
		logic [7:0]         flags;
		logic [31:0]        arrival_ticks;
	} record_t;

	typedef struct {
		logic [3:0]  status;
		logic [31:0] generation;
		logic [15:0] current_sequence;
		logic        has_record;
		logic [31:0] published_count;
		logic [31:0] duplicate_count;
		logic [31:0] stale_count;
		logic [31:0] rejected_count;
	} outcome_t;

	typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_LONG} rx_mode_e;

	class record_scoreboard;
		logic [7:0]  max_condition;
		logic [15:0] ttl_min;
		logic [15:0] ttl_max;
		logic [7:0]  flag_mask;
		logic        published_once;
		logic [15:0] last_seq;
		logic [31:0] generation;
		logic [31:0] n_published;
		logic [31:0] n_duplicate;
		logic [31:0] n_stale;
		logic [31:0] n_rejected;
		outcome_t    expected_q[$];
		int          mismatches;
		int          checked;

		function new();
			max_condition  = 8'd4;
			ttl_min        = 16'd1;
			ttl_max        = 16'd1440;
			flag_mask      = 8'd3;
			published_once = 1'b0;
			last_seq       = '0;
			generation     = '0;
			n_published    = '0;
			n_duplicate    = '0;
			n_stale        = '0;
			n_rejected     = '0;
			mismatches     = 0;
			checked        = 0;
		endfunction

		function void write_register(logic [7:0] index, logic [15:0] data);
			case (index)
				CFG_MAX_CONDITION: max_condition = data[7:0];
				CFG_TTL_MIN:       ttl_min = data;
				CFG_TTL_MAX:       ttl_max = data;
				CFG_FLAG_MASK:     flag_mask = data[7:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] bump(logic [31:0] c);
			return (c == '1) ? c : c + 32'd1;
		endfunction

		// first failing check wins
		function logic [3:0] field_status(record_t r);
			if (r.length != LIM_LENGTH) return ST_LENGTH;
			if (r.condition > max_condition) return ST_CONDITION;
			if (r.temperature < LIM_TEMP_LO || r.temperature > LIM_TEMP_HI)
				return ST_TEMPERATURE;
			if (r.observed_time < LIM_TIME_LO || r.observed_time > LIM_TIME_HI)
				return ST_TIME;
			if (r.lifetime < ttl_min || r.lifetime > ttl_max) return ST_LIFETIME;
			if ((r.flags & ~flag_mask) != 8'd0 || r.flags == flag_mask) return ST_FLAGS;
			return ST_PUBLISHED;
		endfunction

		function void note_record(record_t r);
			outcome_t    o;
			logic [15:0] ahead;
			o.status = field_status(r);
			ahead = r.seq - last_seq;
			if (o.status != ST_PUBLISHED) begin
				n_rejected = bump(n_rejected);
			end else if (published_once && ahead == 16'd0) begin
				o.status = ST_DUPLICATE;
				n_duplicate = bump(n_duplicate);
			end else if (published_once && ahead >= LIM_HALF) begin
				// from one step up to half the range behind counts as older
				o.status = ST_STALE;
				n_stale = bump(n_stale);
			end else begin
				last_seq = r.seq;
				generation = generation + 32'd1;
				published_once = 1'b1;
				n_published = bump(n_published);
			end
			o.generation       = generation;
			o.current_sequence = last_seq;
			o.has_record       = published_once;
			o.published_count  = n_published;
			o.duplicate_count  = n_duplicate;
			o.stale_count      = n_stale;
			o.rejected_count   = n_rejected;
			expected_q.push_back(o);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			$display("[%0t] result %0d %s: got %0h expected %0h",
				$time, checked, what, got, want);
		endtask

		task check_result(outcome_t got);
			outcome_t want;
			checked++;
			if (expected_q.size() == 0) begin
				report("arrived with nothing expected, status", got.status, '0);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status) report("status", got.status, want.status);
			if (got.generation !== want.generation)
				report("generation", got.generation, want.generation);
			if (got.current_sequence !== want.current_sequence)
				report("current_sequence", got.current_sequence, want.current_sequence);
			if (got.has_record !== want.has_record)
				report("has_record", got.has_record, want.has_record);
			if (got.published_count !== want.published_count)
				report("published_count", got.published_count, want.published_count);
			if (got.duplicate_count !== want.duplicate_count)
				report("duplicate_count", got.duplicate_count, want.duplicate_count);
			if (got.stale_count !== want.stale_count)
				report("stale_count", got.stale_count, want.stale_count);
			if (got.rejected_count !== want.rejected_count)
				report("rejected_count", got.rejected_count, want.rejected_count);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	srv_rec_if rec_ch();
	srv_res_if res_ch();
	srv_cfg_if cfg_ch();

	sequenced_record_validator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.rec(rec_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	record_scoreboard sb = new();

	int       cycles = 0;
	int       records_sent = 0;
	int       writes_done = 0;
	int       burst_left = 0;
	rx_mode_e rx_mode = RX_OPEN;
	int       mode_left = 0;
	int       stall_left = 0;
	record_t  seen_record;
	outcome_t seen_result;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, sb.expected_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side stalls, switching pattern whenever a randomly drawn mode length runs out
	always @(posedge clk) begin
		if (mode_left == 0) begin
			rx_mode <= rx_mode_e'($urandom_range(0, 3));
			mode_left <= $urandom_range(40, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (rx_mode)
			RX_OPEN: res_ch.ready <= 1'b1;
			RX_COIN: res_ch.ready <= ($urandom_range(0, 1) == 1);
			RX_PERIODIC: res_ch.ready <= ((cycles % 5) < 2);
			default: begin
				if (stall_left > 0) begin
					res_ch.ready <= 1'b0;
					stall_left <= stall_left - 1;
				end else begin
					res_ch.ready <= 1'b1;
					if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 20);
				end
			end
		endcase
	end

	// results checked before the record taken at the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				seen_result.status           = res_ch.status;
				seen_result.generation       = res_ch.generation;
				seen_result.current_sequence = res_ch.current_sequence;
				seen_result.has_record       = res_ch.has_record;
				seen_result.published_count  = res_ch.published_count;
				seen_result.duplicate_count  = res_ch.duplicate_count;
				seen_result.stale_count      = res_ch.stale_count;
				seen_result.rejected_count   = res_ch.rejected_count;
				sb.check_result(seen_result);
			end
			if (rec_ch.valid && rec_ch.ready) begin
				seen_record.seq           = rec_ch.sequence_req;
				seen_record.length        = rec_ch.length;
				seen_record.condition     = rec_ch.condition;
				seen_record.temperature   = rec_ch.temperature;
				seen_record.observed_time = rec_ch.observed_time;
				seen_record.lifetime      = rec_ch.lifetime;
				seen_record.flags         = rec_ch.flags;
				seen_record.arrival_ticks = rec_ch.arrival_ticks;
				sb.note_record(seen_record);
			end
		end
	end

	function automatic logic [31:0] near_edges(logic [31:0] lo, logic [31:0] hi);
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	// passes every check under the reset settings
	function automatic record_t plain_record(logic [15:0] seq);
		record_t r;
		r.seq           = seq;
		r.length        = LIM_LENGTH;
		r.condition     = 8'd2;
		r.temperature   = 16'sd215;
		r.observed_time = 32'd1700000000;
		r.lifetime      = 16'd60;
		r.flags         = 8'h01;
		r.arrival_ticks = $urandom;
		return r;
	endfunction

	function automatic record_t random_record();
		record_t     r;
		logic [15:0] seq;
		int          b;
		case ($urandom_range(0, 9))
			0, 1, 2: seq = sb.last_seq + 16'($urandom_range(1, 4));
			3: seq = sb.last_seq;
			4: seq = sb.last_seq - 16'($urandom_range(1, 4));
			5: seq = sb.last_seq + LIM_HALF;
			6: seq = sb.last_seq + 16'h7FFF;
			7: seq = sb.last_seq + 16'h8001;
			default: seq = 16'($urandom);
		endcase
		r = plain_record(seq);
		if ($urandom_range(0, 9) == 0) begin
			r.seq           = 16'($urandom);
			r.length        = 8'($urandom);
			r.condition     = 8'($urandom);
			r.temperature   = 16'($urandom);
			r.observed_time = $urandom;
			r.lifetime      = 16'($urandom);
			r.flags         = 8'($urandom);
			return r;
		end
		r.condition     = 8'($urandom_range(0, sb.max_condition));
		r.temperature   = 16'(int'(near_edges(0, 1100)) - 500);
		r.observed_time = near_edges(LIM_TIME_LO, LIM_TIME_HI);
		if (sb.ttl_min <= sb.ttl_max) r.lifetime = 16'(near_edges(sb.ttl_min, sb.ttl_max));
		else r.lifetime = 16'($urandom);
		r.flags = 8'($urandom) & sb.flag_mask;
		if (r.flags == sb.flag_mask) r.flags = 8'd0;
		if ($urandom_range(0, 9) < 3) begin
			case (4'($urandom_range(ST_LENGTH, ST_FLAGS)))
				ST_LENGTH: begin
					r.length = 8'($urandom);
					if (r.length == LIM_LENGTH) r.length = 8'd9;
				end
				ST_CONDITION: begin
					if (sb.max_condition != 8'hFF)
						r.condition = 8'(near_edges(sb.max_condition + 1, 255));
				end
				ST_TEMPERATURE: begin
					if ($urandom_range(0, 1) == 0) r.temperature = 16'(near_edges(601, 32767));
					else r.temperature = 16'(-int'(near_edges(501, 32768)));
				end
				ST_TIME: begin
					if ($urandom_range(0, 1) == 0)
						r.observed_time = near_edges(0, LIM_TIME_LO - 1);
					else
						r.observed_time = near_edges(LIM_TIME_HI + 1, 32'hFFFF_FFFF);
				end
				ST_LIFETIME: begin
					if (sb.ttl_min != 0 && (sb.ttl_max == 16'hFFFF || $urandom_range(0, 1) == 0))
						r.lifetime = 16'(near_edges(0, sb.ttl_min - 1));
					else if (sb.ttl_max != 16'hFFFF)
						r.lifetime = 16'(near_edges(sb.ttl_max + 1, 16'hFFFF));
				end
				default: begin
					if (sb.flag_mask == 8'hFF || $urandom_range(0, 1) == 0) begin
						r.flags = sb.flag_mask;
					end else begin
						do b = $urandom_range(0, 7); while (sb.flag_mask[b]);
						r.flags[b] = 1'b1;
					end
				end
			endcase
		end
		return r;
	endfunction

	task automatic send_record(record_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				rec_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		rec_ch.valid         <= 1'b1;
		rec_ch.sequence_req  <= r.seq;
		rec_ch.length        <= r.length;
		rec_ch.condition     <= r.condition;
		rec_ch.temperature   <= r.temperature;
		rec_ch.observed_time <= r.observed_time;
		rec_ch.lifetime      <= r.lifetime;
		rec_ch.flags         <= r.flags;
		rec_ch.arrival_ticks <= r.arrival_ticks;
		do @(posedge clk); while (!rec_ch.ready);
		records_sent++;
	endtask

	task automatic drain();
		rec_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	task automatic run_records(int count);
		repeat (count) send_record(random_record());
		drain();
	endtask

	task automatic put_register(logic [7:0] index, logic [15:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_register(index, data);
		writes_done++;
	endtask

	// upper data bits of the 8-bit registers carry junk
	task automatic write_settings(logic [7:0] mc, logic [15:0] tmin, logic [15:0] tmax,
			logic [7:0] mask, bit stray);
		put_register(CFG_MAX_CONDITION, {8'($urandom), mc});
		put_register(CFG_TTL_MIN, tmin);
		put_register(CFG_TTL_MAX, tmax);
		put_register(CFG_FLAG_MASK, {8'($urandom), mask});
		if (stray) begin
			put_register(CFG_UNUSED_LOW, 16'($urandom));
			put_register(CFG_UNUSED_TOP, 16'($urandom));
		end
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		record_t     r;
		logic [15:0] tmin_r;
		logic [15:0] tmax_r;
		logic [15:0] swap;

		arst_n = 1'b0;
		rec_ch.valid = 1'b0;
		rec_ch.sequence_req = '0;
		rec_ch.length = '0;
		rec_ch.condition = '0;
		rec_ch.temperature = '0;
		rec_ch.observed_time = '0;
		rec_ch.lifetime = '0;
		rec_ch.flags = '0;
		rec_ch.arrival_ticks = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field checks and their order, before anything is published
		r = plain_record(16'd100); r.length = 8'd0; send_record(r);
		r = plain_record(16'd200); r.length = 8'hFF; r.condition = 8'hFF; send_record(r);
		r = plain_record(16'd200); r.condition = 8'hFF; r.temperature = -16'sd32768;
		send_record(r);
		r = plain_record(16'd200); r.condition = 8'd5; send_record(r);
		r = plain_record(16'd200); r.temperature = -16'sd501; send_record(r);
		r = plain_record(16'd200); r.temperature = 16'sd601; send_record(r);
		r = plain_record(16'd200); r.observed_time = LIM_TIME_LO - 1; send_record(r);
		r = plain_record(16'd200); r.observed_time = 32'hFFFF_FFFF; send_record(r);
		r = plain_record(16'd200); r.lifetime = 16'd0; send_record(r);
		r = plain_record(16'd200); r.lifetime = 16'd1441; send_record(r);
		r = plain_record(16'd200); r.flags = 8'h03; send_record(r);
		r = plain_record(16'd200); r.flags = 8'h80; send_record(r);
		// first publication at the lower field limits and the condition maximum, then sequence rules
		r = plain_record(16'hFFFF); r.temperature = -16'sd500; r.observed_time = LIM_TIME_LO;
		r.lifetime = 16'd1; r.flags = 8'h00; r.condition = 8'd4; send_record(r);
		r = plain_record(16'hFFFF); send_record(r);
		r = plain_record(16'hFFFE); send_record(r);
		r = plain_record(16'h0000); r.temperature = 16'sd600; r.observed_time = LIM_TIME_HI;
		r.lifetime = 16'd1440; r.flags = 8'h02; r.condition = 8'd0; send_record(r);
		r = plain_record(16'h8000); send_record(r);
		r = plain_record(16'h7FFF); send_record(r);
		r = plain_record(16'hFFFF); send_record(r);
		r = plain_record(16'hFFFE); send_record(r);
		r = plain_record(16'hFFFE); r.length = 8'd9; send_record(r);
		r = plain_record(16'h0000); r.temperature = 16'sh7FFF; send_record(r);
		drain();

		run_records(140);
		write_settings(8'hFF, 16'd0, 16'hFFFF, 8'hFF, 1'b0);
		run_records(140);
		write_settings(8'd0, 16'd0, 16'd0, 8'h81, 1'b1);
		run_records(100);
		tmin_r = 16'($urandom);
		tmax_r = 16'($urandom);
		if (tmin_r > tmax_r) begin
			swap = tmin_r;
			tmin_r = tmax_r;
			tmax_r = swap;
		end
		write_settings(8'($urandom), tmin_r, tmax_r, 8'($urandom) | 8'h01, 1'b1);
		run_records(140);
		// crossed lifetime bounds reject every lifetime
		write_settings(8'd4, 16'd500, 16'd499, 8'h03, 1'b0);
		run_records(40);
		// empty mask rejects every flag byte
		write_settings(8'd4, 16'd1, 16'd1440, 8'h00, 1'b0);
		run_records(40);
		write_settings(8'd4, 16'd1, 16'd1440, 8'h03, 1'b1);
		run_records(100);

		repeat (20) @(posedge clk);
		$display("%0d records, %0d results checked, %0d register writes, %0d cycles",
			records_sent, sb.checked, writes_done, cycles);
		$display("outcomes: %0d published, %0d duplicate, %0d stale, %0d rejected",
			sb.n_published, sb.n_duplicate, sb.n_stale, sb.n_rejected);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
